FILE: rtl/core/config_text_tokenizer_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef CONFIG_TEXT_TOKENIZER_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define CTT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");
// Condition must never be true outside reset.
`define CTT_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");
`else
`define CTT_ASSERT(name, clk, rst_n, prop)
`define CTT_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

FILE: rtl/core/cfgtok_pkg.sv
// Shared types, token kinds, character constants and byte classifiers.
package cfgtok_pkg;

    localparam logic [3:0] KIND_LPAREN   = 4'd0;
    localparam logic [3:0] KIND_RPAREN   = 4'd1;
    localparam logic [3:0] KIND_LBRACE   = 4'd2;
    localparam logic [3:0] KIND_RBRACE   = 4'd3;
    localparam logic [3:0] KIND_LBRACKET = 4'd4;
    localparam logic [3:0] KIND_RBRACKET = 4'd5;
    localparam logic [3:0] KIND_COMMA    = 4'd6;
    localparam logic [3:0] KIND_COLON    = 4'd7;
    localparam logic [3:0] KIND_SEMI     = 4'd8;
    localparam logic [3:0] KIND_STRING   = 4'd9;
    localparam logic [3:0] KIND_IDENT    = 4'd10;
    localparam logic [3:0] KIND_END      = 4'd11;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // One output word.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       txt;
        logic       tend;
        logic       ab;
    } t_result;

    // All words caused by one input byte; cnt is 1..3 when queued.
    typedef struct packed {
        t_result [2:0] res;
        logic    [1:0] cnt;
    } t_group;

    function automatic logic is_alnum(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_alnum(b) || (b inside {CH_UNDER, CH_DOT, CH_DASH});
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return b inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                         CH_RBRACKET, CH_COMMA, CH_COLON, CH_SEMI};
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] b);
        logic [3:0] k;
        case (b)
            CH_LPAREN:   k = KIND_LPAREN;
            CH_RPAREN:   k = KIND_RPAREN;
            CH_LBRACE:   k = KIND_LBRACE;
            CH_RBRACE:   k = KIND_RBRACE;
            CH_LBRACKET: k = KIND_LBRACKET;
            CH_RBRACKET: k = KIND_RBRACKET;
            CH_COMMA:    k = KIND_COMMA;
            CH_COLON:    k = KIND_COLON;
            CH_SEMI:     k = KIND_SEMI;
            default:     k = KIND_END;
        endcase
        return k;
    endfunction

    function automatic t_result mk_res(input logic [3:0] kind, input logic [7:0] ch,
                                       input logic txt, input logic tend, input logic ab);
        t_result r;
        r.kind = kind;
        r.ch   = ch;
        r.txt  = txt;
        r.tend = tend;
        r.ab   = ab;
        return r;
    endfunction

endpackage

FILE: rtl/core/cfgtok_front.sv
// Front end: scan state machine that turns each accepted byte into a word group.
module cfgtok_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_final,
    output logic                  o_wr,
    output cfgtok_pkg::t_group    o_grp
);
    import cfgtok_pkg::*;

    typedef enum logic [6:0] {
        PH_SKIP    = 7'b0000001,
        PH_SLASH   = 7'b0000010,
        PH_COMMENT = 7'b0000100,
        PH_STRING  = 7'b0001000,
        PH_ESCAPE  = 7'b0010000,
        PH_IDENT   = 7'b0100000,
        PH_DRAIN   = 7'b1000000
    } t_phase;

    t_phase r_phase, n_phase;
    t_group grp;
    logic   do_between;

    function automatic logic tok_open(input t_phase ph);
        return (ph == PH_STRING) || (ph == PH_ESCAPE) || (ph == PH_IDENT);
    endfunction

    always_comb begin
        grp        = '0;
        n_phase    = r_phase;
        do_between = 1'b0;
        if (r_phase == PH_DRAIN) begin
            // rest of text after an early zero byte is dropped
            n_phase = i_final ? PH_SKIP : PH_DRAIN;
        end else if (i_byte == CH_NUL) begin
            grp.res[grp.cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, tok_open(r_phase));
            grp.cnt          = grp.cnt + 2'd1;
            n_phase          = i_final ? PH_SKIP : PH_DRAIN;
        end else begin
            case (r_phase)
                PH_COMMENT: begin
                    if (i_byte == CH_NL) n_phase = PH_SKIP;
                end
                PH_STRING: begin
                    if (i_byte == CH_QUOTE) begin
                        grp.res[grp.cnt] = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                        n_phase          = PH_SKIP;
                    end else if (i_byte == CH_BSLASH) begin
                        n_phase = PH_ESCAPE;
                    end else if (i_byte != CH_NL) begin
                        grp.res[grp.cnt] = mk_res(KIND_STRING, i_byte, 1'b1, 1'b0, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                    end
                end
                PH_ESCAPE: begin
                    if (i_byte != CH_NL) begin
                        grp.res[grp.cnt] = mk_res(KIND_STRING, i_byte, 1'b1, 1'b0, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                    end
                    n_phase = PH_STRING;
                end
                PH_IDENT: begin
                    if (is_ident_char(i_byte)) begin
                        grp.res[grp.cnt] = mk_res(KIND_IDENT, i_byte, 1'b1, 1'b0, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                    end else begin
                        // terminator is rescanned as a between-token byte
                        grp.res[grp.cnt] = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b1, 1'b0);
                        grp.cnt          = grp.cnt + 2'd1;
                        do_between       = 1'b1;
                    end
                end
                PH_SLASH: begin
                    if (i_byte == CH_SLASH) n_phase = PH_COMMENT;
                    else                    do_between = 1'b1;
                end
                default: do_between = 1'b1;
            endcase

            if (do_between) begin
                n_phase = PH_SKIP;
                if (i_byte == CH_SLASH) begin
                    n_phase = PH_SLASH;
                end else if (is_punct(i_byte)) begin
                    grp.res[grp.cnt] = mk_res(punct_kind(i_byte), 8'h00, 1'b0, 1'b1, 1'b0);
                    grp.cnt          = grp.cnt + 2'd1;
                end else if (i_byte == CH_QUOTE) begin
                    n_phase = PH_STRING;
                end else if (is_alnum(i_byte)) begin
                    n_phase          = PH_IDENT;
                    grp.res[grp.cnt] = mk_res(KIND_IDENT, i_byte, 1'b1, 1'b0, 1'b0);
                    grp.cnt          = grp.cnt + 2'd1;
                end
            end

            if (i_final) begin
                grp.res[grp.cnt] = mk_res(KIND_END, 8'h00, 1'b0, 1'b1, tok_open(n_phase));
                grp.cnt          = grp.cnt + 2'd1;
                n_phase          = PH_SKIP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    assign o_grp = grp;
    assign o_wr  = i_accept && (grp.cnt != 2'd0);

endmodule

FILE: rtl/core/cfgtok_queue.sv
// Group queue between the front and back ends (flop array, one write and one read).
`include "config_text_tokenizer_defines.svh"
module cfgtok_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  cfgtok_pkg::t_group    i_data,
    input  logic                  i_rd,
    output cfgtok_pkg::t_group    o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import cfgtok_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [IW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : IW'(p + 1'b1);
    endfunction

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd)      n_count = CW'(r_count + 1'b1);
        else if (!i_wr && i_rd) n_count = CW'(r_count - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_rd) r_rd_ptr <= ptr_inc(r_rd_ptr);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    `CTT_ASSERT_NEVER(a_no_wr_full, i_clk, i_rst_n, i_wr && o_full)
    `CTT_ASSERT_NEVER(a_no_rd_empty, i_clk, i_rst_n, i_rd && o_empty)
    `CTT_ASSERT(a_count_up, i_clk, i_rst_n, (i_wr && !i_rd) |=> r_count == CW'($past(r_count) + 1'b1))

endmodule

FILE: rtl/core/cfgtok_back.sv
// Back end: unpacks word groups and presents one word at a time to the consumer.
`include "config_text_tokenizer_defines.svh"
module cfgtok_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfgtok_pkg::t_group    i_grp,
    input  logic                  i_q_empty,
    output logic                  o_q_rd,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [3:0]            o_token_kind,
    output logic [7:0]            o_text_byte_out,
    output logic                  o_has_text,
    output logic                  o_token_end,
    output logic                  o_abandoned,
    output logic                  o_last_result
);
    import cfgtok_pkg::*;

    t_group     r_grp;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       at_last;
    logic       advance;
    t_result    cur;

    assign at_last = (r_idx == 2'(r_grp.cnt - 2'd1));
    // take the next group when idle or when the last word of this one leaves
    assign advance = !r_valid || (i_pop && at_last);
    assign o_q_rd  = advance && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= !i_q_empty;
            r_idx   <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) r_grp <= i_grp;
    end

    assign cur             = r_grp.res[r_idx];
    assign o_empty         = !r_valid;
    assign o_token_kind    = cur.kind;
    assign o_text_byte_out = cur.ch;
    assign o_has_text      = cur.txt;
    assign o_token_end     = cur.tend;
    assign o_abandoned     = cur.ab;
    assign o_last_result   = at_last;

    `CTT_ASSERT(a_grp_nonempty, i_clk, i_rst_n, r_valid |-> r_grp.cnt != 2'd0)
    `CTT_ASSERT(a_idx_in_grp, i_clk, i_rst_n, r_valid |-> r_idx < r_grp.cnt)
    `CTT_ASSERT(a_hold_stall, i_clk, i_rst_n, (r_valid && !i_pop) |=> r_valid && $stable(r_idx))

endmodule

FILE: rtl/core/config_text_tokenizer.sv
// Streaming tokenizer for configuration text with line comments.
//
// Input channel: one text byte per word with a final-byte flag; a word is
// taken on a clock edge with push high and full low. Result channel: token
// words with kind, optional text character and end/abandon/last flags; the
// oldest word is shown while empty is low and leaves on an edge with pop high.
// A byte's word group is registered in the queue, then in the output stage,
// before its first word shows. Throughput: one byte per cycle into the scanner
// while full is low. Each byte yields zero to three words; the output side
// delivers one word per cycle while pop is high. A queue of QUEUE_DEPTH word
// groups sits between scanner and output; full rises only when it fills.
// Reset (synchronous, active low) puts the scanner between tokens and
// empties the queue and output stage. While pop stays low, the shown word
// holds and bytes keep flowing until the queue fills.
module config_text_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_byte_in,
    input  logic       i_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_token_kind,
    output logic [7:0] o_text_byte_out,
    output logic       o_has_text,
    output logic       o_token_end,
    output logic       o_abandoned,
    output logic       o_last_result
);
    import cfgtok_pkg::*;

    logic   accept;
    logic   q_wr, q_rd, q_full, q_empty;
    t_group f_grp, q_grp;

    assign accept = push && !q_full;
    assign full   = q_full;

    cfgtok_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_text_byte_in),
        .i_final  (i_final_byte),
        .o_wr     (q_wr),
        .o_grp    (f_grp)
    );

    cfgtok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (f_grp),
        .i_rd    (q_rd),
        .o_data  (q_grp),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cfgtok_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_grp           (q_grp),
        .i_q_empty       (q_empty),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_token_kind    (o_token_kind),
        .o_text_byte_out (o_text_byte_out),
        .o_has_text      (o_has_text),
        .o_token_end     (o_token_end),
        .o_abandoned     (o_abandoned),
        .o_last_result   (o_last_result)
    );

endmodule

FILE: tb/sv/config_text_tokenizer_tb.sv
// Self-checking testbench for the configuration text tokenizer.
module config_text_tokenizer_tb;
    import cfgtok_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int STEADY_ITEMS = 80;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_DIG_FIRST = 8'h30;
    localparam logic [7:0] CH_DIG_LAST  = 8'h39;
    localparam logic [7:0] CH_UP_FIRST  = 8'h41;
    localparam logic [7:0] CH_UP_LAST   = 8'h5A;
    localparam logic [7:0] CH_LOW_FIRST = 8'h61;
    localparam logic [7:0] CH_LOW_LAST  = 8'h7A;
    localparam logic [7:0] CH_HIGH_MIN  = 8'h80;
    localparam logic [7:0] CH_HIGH_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        SCAN_GAP, SCAN_SLASH, SCAN_COMMENT, SCAN_STR, SCAN_ESC, SCAN_IDENT, SCAN_DRAIN
    } t_scan;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       txt;
        logic       tend;
        logic       ab;
        logic       last;
    } t_token_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_text_byte_in = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [3:0] o_token_kind;
    logic [7:0] o_text_byte_out;
    logic       o_has_text;
    logic       o_token_end;
    logic       o_abandoned;
    logic       o_last_result;

    t_scan       scan = SCAN_GAP;
    t_token_word pending_words[$];
    t_token_word seen_word;
    t_token_word wanted_word;
    logic [7:0]  text_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          content_items = 0;
    int          pop_hold = 0;
    bit          bursty = 1'b1;

    logic [7:0] punct_set [9] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACKET,
                                  CH_RBRACKET, CH_COMMA, CH_COLON, CH_SEMI};
    logic [7:0] ident_marks [3] = '{CH_UNDER, CH_DOT, CH_DASH};

    config_text_tokenizer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte_in (i_text_byte_in),
        .i_final_byte   (i_final_byte),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_text_byte_out(o_text_byte_out),
        .o_has_text     (o_has_text),
        .o_token_end    (o_token_end),
        .o_abandoned    (o_abandoned),
        .o_last_result  (o_last_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- expected token words ----------------

    function automatic logic letter_or_digit(input logic [7:0] b);
        return (b >= CH_UP_FIRST && b <= CH_UP_LAST) || (b >= CH_LOW_FIRST && b <= CH_LOW_LAST) ||
               (b >= CH_DIG_FIRST && b <= CH_DIG_LAST);
    endfunction

    function automatic logic token_open();
        return scan inside {SCAN_STR, SCAN_ESC, SCAN_IDENT};
    endfunction

    function automatic void add_word(input logic [3:0] kind, input logic [7:0] ch,
                                     input logic txt, input logic tend, input logic ab);
        t_token_word w;
        w = {kind, ch, txt, tend, ab, 1'b0};
        pending_words.push_back(w);
    endfunction

    function automatic void between_tokens(input logic [7:0] b);
        scan = SCAN_GAP;
        case (b)
            CH_SLASH:    scan = SCAN_SLASH;
            CH_QUOTE:    scan = SCAN_STR;
            CH_LPAREN:   add_word(KIND_LPAREN, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_RPAREN:   add_word(KIND_RPAREN, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_LBRACE:   add_word(KIND_LBRACE, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_RBRACE:   add_word(KIND_RBRACE, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_LBRACKET: add_word(KIND_LBRACKET, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_RBRACKET: add_word(KIND_RBRACKET, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_COMMA:    add_word(KIND_COMMA, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_COLON:    add_word(KIND_COLON, CH_NUL, 1'b0, 1'b1, 1'b0);
            CH_SEMI:     add_word(KIND_SEMI, CH_NUL, 1'b0, 1'b1, 1'b0);
            default: begin
                if (letter_or_digit(b)) begin
                    scan = SCAN_IDENT;
                    add_word(KIND_IDENT, b, 1'b1, 1'b0, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        int queued;
        queued = pending_words.size();
        // after an early zero byte the rest of the text makes no words
        if (scan == SCAN_DRAIN) begin
            if (fin)
                scan = SCAN_GAP;
            return;
        end
        if (b == CH_NUL) begin
            add_word(KIND_END, CH_NUL, 1'b0, 1'b1, token_open());
            scan = fin ? SCAN_GAP : SCAN_DRAIN;
        end else begin
            case (scan)
                SCAN_COMMENT: begin
                    if (b == CH_NL)
                        scan = SCAN_GAP;
                end
                SCAN_STR: begin
                    if (b == CH_QUOTE) begin
                        add_word(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b0);
                        scan = SCAN_GAP;
                    end else if (b == CH_BSLASH) begin
                        scan = SCAN_ESC;
                    end else if (b != CH_NL) begin
                        add_word(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
                    end
                end
                SCAN_ESC: begin
                    if (b != CH_NL)
                        add_word(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
                    scan = SCAN_STR;
                end
                SCAN_IDENT: begin
                    if (letter_or_digit(b) || b inside {CH_UNDER, CH_DOT, CH_DASH}) begin
                        add_word(KIND_IDENT, b, 1'b1, 1'b0, 1'b0);
                    end else begin
                        // terminator closes the identifier, then counts as a gap byte
                        add_word(KIND_IDENT, CH_NUL, 1'b0, 1'b1, 1'b0);
                        between_tokens(b);
                    end
                end
                SCAN_SLASH: begin
                    if (b == CH_SLASH)
                        scan = SCAN_COMMENT;
                    else
                        between_tokens(b);
                end
                default: between_tokens(b);
            endcase
            if (fin) begin
                add_word(KIND_END, CH_NUL, 1'b0, 1'b1, token_open());
                scan = SCAN_GAP;
            end
        end
        if (pending_words.size() > queued)
            pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // ---------------- result side ----------------

    function automatic string show_word(input t_token_word w);
        return $sformatf("kind=%0d ch=%02h text=%b end=%b abandoned=%b last=%b",
                         w.kind, w.ch, w.txt, w.tend, w.ab, w.last);
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (bursty && $urandom_range(0, 7) == 0) begin
            pop_hold <= $urandom_range(0, 8);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen_word = {o_token_kind, o_text_byte_out, o_has_text, o_token_end, o_abandoned,
                         o_last_result};
            if (pending_words.size() == 0) begin
                note_error({"unexpected word: ", show_word(seen_word)});
            end else begin
                wanted_word = pending_words.pop_front();
                if (seen_word !== wanted_word)
                    note_error({"word mismatch: expected ", show_word(wanted_word),
                                ", got ", show_word(seen_word)});
            end
        end
    end

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        @(negedge i_clk);
        if (bursty && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_text_byte_in <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (full);
        if (scan != SCAN_DRAIN)
            content_items++;
        predict_byte(b, fin);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'(CH_UP_FIRST + $urandom_range(0, 25));
            1:       return 8'(CH_LOW_FIRST + $urandom_range(0, 25));
            default: return 8'(CH_DIG_FIRST + $urandom_range(0, 9));
        endcase
    endfunction

    // Mostly well-formed config text: identifiers, strings, comments, punctuation.
    task automatic build_random_text();
        int         frag_count;
        int         len;
        logic [7:0] b;
        text_q.delete();
        frag_count = $urandom_range(1, 8);
        repeat (frag_count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    text_q.push_back(rand_alnum());
                    len = $urandom_range(0, 5);
                    repeat (len)
                        text_q.push_back($urandom_range(0, 3) == 0 ?
                                         ident_marks[$urandom_range(0, 2)] : rand_alnum());
                end
                2, 3: begin
                    text_q.push_back(CH_QUOTE);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        case ($urandom_range(0, 7))
                            0: begin
                                text_q.push_back(CH_BSLASH);
                                text_q.push_back(8'($urandom_range(1, 255)));
                            end
                            1: text_q.push_back(CH_NL);
                            2: text_q.push_back(8'($urandom_range(CH_HIGH_MIN, CH_HIGH_MAX)));
                            default: begin
                                b = 8'($urandom_range(CH_SPACE, CH_TILDE));
                                if (b == CH_QUOTE || b == CH_BSLASH)
                                    b = CH_UNDER;
                                text_q.push_back(b);
                            end
                        endcase
                    end
                    if ($urandom_range(0, 7) != 0)
                        text_q.push_back(CH_QUOTE);
                end
                4: begin
                    text_q.push_back(CH_SLASH);
                    text_q.push_back(CH_SLASH);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        b = 8'($urandom_range(1, 255));
                        text_q.push_back(b == CH_NL ? CH_SLASH : b);
                    end
                    if ($urandom_range(0, 3) != 0)
                        text_q.push_back(CH_NL);
                end
                5, 6: text_q.push_back(punct_set[$urandom_range(0, 8)]);
                7: begin
                    case ($urandom_range(0, 2))
                        0:       text_q.push_back(CH_SPACE);
                        1:       text_q.push_back(CH_NL);
                        default: text_q.push_back(CH_TAB);
                    endcase
                end
                8: text_q.push_back(8'($urandom_range(1, 255)));
                default: text_q.push_back($urandom_range(0, 3) == 0 ? CH_NUL : CH_SLASH);
            endcase
        end
        if ($urandom_range(0, 15) == 0)
            text_q.push_back(CH_NUL);
    endtask

    // ---------------- tests ----------------

    task automatic test_punctuation();
        text_q.delete();
        add_text("(){}[],:;");
        send_text();
    endtask

    // identifier cut by a slash, lone slash, then three words on the final byte
    task automatic test_identifiers();
        text_q.delete();
        add_text("a_.9/q;");
        send_text();
    endtask

    // escaped newline, high bytes in and out of a string, comment running to the end
    task automatic test_strings_and_comments();
        text_q = '{CH_QUOTE, CH_BSLASH, CH_NL, CH_HIGH_MAX, CH_QUOTE, CH_HIGH_MIN,
                   CH_SLASH, CH_SLASH, CH_BSLASH};
        send_text();
    endtask

    task automatic test_zero_byte();
        text_q = '{CH_LOW_FIRST, CH_NUL, CH_RPAREN};
        send_text();
        text_q = '{CH_NUL};
        send_text();
        text_q = '{CH_QUOTE, CH_LOW_LAST};
        send_text();
    endtask

    task automatic test_random_texts(input int items, input bit idling);
        int target;
        target = content_items + items;
        while (content_items < target) begin
            bursty = idling && ($urandom_range(0, 3) != 0);
            build_random_text();
            send_text();
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_punctuation();
        test_identifiers();
        test_strings_and_comments();
        test_zero_byte();
        test_random_texts(RANDOM_ITEMS, 1'b1);
        test_random_texts(STEADY_ITEMS, 1'b0);
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: config_text_tokenizer.f
+incdir+rtl/core
rtl/core/cfgtok_pkg.sv
rtl/core/cfgtok_front.sv
rtl/core/cfgtok_queue.sv
rtl/core/cfgtok_back.sv
rtl/core/config_text_tokenizer.sv
tb/sv/config_text_tokenizer_tb.sv
